// File: rtl/tile_cholesky_factor_unit_defines.svh
// ----------------------------------------------------------------------------
// tile cholesky factor unit assertion macros
// assertion helpers used by the controller
// ----------------------------------------------------------------------------
`ifndef TILE_CHOLESKY_FACTOR_UNIT_DEFINES_SVH
`define TILE_CHOLESKY_FACTOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TCF_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define TCF_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define TCF_ASSERT_IMP(lbl, clk, rst, a, c)
`define TCF_ASSERT_NXT(lbl, clk, rst, a, c)
`endif
`endif

// File: rtl/tcf_pkg.sv
// ----------------------------------------------------------------------------
// tcf_pkg
// shared types and constants of the tile cholesky factor unit
// ----------------------------------------------------------------------------
package tcf_pkg;
  localparam int unsigned TILE_MAX   = 8;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned IDX_W = 3;
  localparam int unsigned VAL_W = VALUE_BITS;
  localparam int unsigned ORD_W = 4;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_PIV_RD,
    OP_ROOT,
    OP_DIV_RD,
    OP_DIV,
    OP_UPD_RD,
    OP_UPD_MUL,
    OP_UPD_WR,
    OP_OUT_RD
  } op_t;

  typedef struct packed {
    op_t  op;
    idx_t i;
    idx_t j;
    idx_t k;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic piv_bad;
  } sts_t;
endpackage

// File: rtl/tcf_in_if.sv
// ----------------------------------------------------------------------------
// tcf_in_if
// load request channel
// ----------------------------------------------------------------------------
interface tcf_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         row;
  logic [2:0]         col;
  logic signed [31:0] value;
  logic               last;
  modport source (output valid, row, col, value, last, input ready);
  modport sink   (input valid, row, col, value, last, output ready);
endinterface

// File: rtl/tcf_out_if.sv
// ----------------------------------------------------------------------------
// tcf_out_if
// result request channel
// ----------------------------------------------------------------------------
interface tcf_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         out_row;
  logic [2:0]         out_col;
  logic signed [31:0] out_value;
  logic               status;
  logic               out_last;
  modport source (output valid, out_row, out_col, out_value, status, out_last,
                  input ready);
  modport sink   (input valid, out_row, out_col, out_value, status, out_last,
                  output ready);
endinterface

// File: rtl/tcf_datapath.sv
// ----------------------------------------------------------------------------
// tcf_datapath
// tile and factor memories, shared bit-serial root/divide unit, multiplier
// ----------------------------------------------------------------------------
module tcf_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              ld_en,
  input  tcf_pkg::idx_t     ld_row,
  input  tcf_pkg::idx_t     ld_col,
  input  tcf_pkg::val_t     ld_value,
  input  tcf_pkg::cmd_t     cmd,
  output tcf_pkg::sts_t     sts,
  output tcf_pkg::val_t     rd_value
);
  import tcf_pkg::*;

  localparam int DEPTH = 64;

  val_t tile_mem [DEPTH];
  val_t fact_mem [DEPTH];

  val_t tile_q;
  val_t fact_a;
  val_t fact_b;
  val_t piv;
  val_t root;
  logic signed [63:0] prod;

  // iterative unit
  logic [5:0]  cnt;
  logic        run;
  logic        mode_div;
  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dvs;
  logic        neg;
  logic [63:0] rem_next;
  logic [63:0] trial;
  logic [63:0] quo_next;

  logic [5:0] a_tile;
  logic [5:0] a_fij;
  logic [5:0] a_fjk;

  logic signed [63:0] diff;
  logic signed [63:0] flo;
  val_t sat_q;

  function automatic val_t sat64(input logic signed [63:0] x);
    if (x > 64'sh7fffffff) begin
      return 32'sh7fffffff;
    end else if (x < -64'sh80000000) begin
      return 32'sh80000000;
    end else begin
      return x[31:0];
    end
  endfunction

  assign a_tile = {cmd.i, cmd.j};
  assign a_fij  = {cmd.i, cmd.k};
  assign a_fjk  = {cmd.j, cmd.k};

  always_ff @(posedge clk) begin
    if (ld_en) begin
      tile_mem[{ld_row, ld_col}] <= ld_value;
    end else if (cmd.op == OP_UPD_WR) begin
      tile_mem[a_tile] <= sat_q;
    end
    tile_q <= tile_mem[a_tile];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ROOT && !run && cnt == 6'd63) begin
      fact_mem[{cmd.k, cmd.k}] <= quo[31:0];
    end else if (cmd.op == OP_DIV && !run && cnt == 6'd63) begin
      fact_mem[a_fij] <= sat_q;
    end
    fact_a <= fact_mem[a_fij];
    fact_b <= fact_mem[a_fjk];
  end

  assign flo  = prod >>> 16;
  assign diff = {{32{tile_q[31]}}, tile_q} - flo;

  always_comb begin
    trial    = '0;
    rem_next = rem;
    quo_next = quo;
    if (mode_div) begin
      trial = {rem[62:0], dvs[63]};
      if (trial >= {32'd0, root}) begin
        rem_next = trial - {32'd0, root};
        quo_next = {dvs[62:0], 1'b1};
      end else begin
        rem_next = trial;
        quo_next = {dvs[62:0], 1'b0};
      end
    end else begin
      trial = {quo[61:0], 2'b01};
      rem_next = {rem[61:0], dvs[63:62]};
      if (rem_next >= trial) begin
        rem_next = rem_next - trial;
        quo_next = {quo[62:0], 1'b1};
      end else begin
        quo_next = {quo[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (!run && (cmd.op == OP_ROOT || cmd.op == OP_DIV) && cnt != 6'd63) begin
      run      <= 1'b1;
      mode_div <= (cmd.op == OP_DIV);
      rem      <= '0;
      quo      <= '0;
      neg      <= tile_q[31];
      if (cmd.op == OP_DIV) begin
        dvs <= {16'd0, (tile_q[31] ? -tile_q : tile_q), 16'd0};
        cnt <= 6'd0;
      end else begin
        dvs <= {16'd0, piv, 16'd0};
        cnt <= 6'd32;
      end
    end else if (run) begin
      rem <= rem_next;
      if (mode_div) begin
        dvs <= quo_next;
      end else begin
        quo <= quo_next;
        dvs <= {dvs[61:0], 2'b00};
      end
      if (cnt == 6'd63) begin
        run <= 1'b0;
      end else begin
        cnt <= cnt + 6'd1;
      end
    end else if (cnt == 6'd63) begin
      cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_PIV_RD) begin
      piv <= tile_mem[{cmd.k, cmd.k}];
    end
    if (!run && !mode_div && cnt == 6'd63) begin
      root <= quo[31:0];
    end
    if (cmd.op == OP_UPD_MUL) begin
      prod <= fact_a * fact_b;
    end
  end

  always_comb begin
    if (cmd.op == OP_DIV) begin
      sat_q = neg ? sat64(-$signed(dvs)) : sat64($signed(dvs));
    end else begin
      sat_q = sat64(diff);
    end
  end

  assign sts.busy     = run || (cnt != 6'd63 && (cmd.op == OP_ROOT || cmd.op == OP_DIV));
  assign sts.piv_bad  = (piv[31] || piv == '0);
  assign rd_value     = (cmd.op == OP_PIV_RD) ? piv : fact_a;
endmodule

// File: rtl/tcf_controller.sv
// ----------------------------------------------------------------------------
// tcf_controller
// load handshake, factorization sequencer and result output register
// ----------------------------------------------------------------------------
`include "tile_cholesky_factor_unit_defines.svh"
module tcf_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic [3:0]        tile_order,
  tcf_in_if.sink            in_ch,
  tcf_out_if.source         out_ch,
  output logic              ld_en,
  output tcf_pkg::cmd_t     cmd,
  input  tcf_pkg::sts_t     sts,
  input  tcf_pkg::val_t     rd_value
);
  import tcf_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_PIV, S_PIV_CHK, S_ROOT, S_DIV_RD, S_DIV, S_UPD_RD, S_UPD_MUL,
    S_UPD_WR, S_OUT_RD, S_OUT_WAIT, S_OUT, S_ERR
  } state_t;

  state_t state;
  idx_t i, j, k, nm1;
  logic   wait1;

  assign nm1 = (tile_order == 4'd0) ? 3'd0 :
               (tile_order > ORD_W'(TILE_MAX)) ? IDX_W'(TILE_MAX - 1) :
               3'(tile_order - 4'd1);
  assign in_ch.ready = (state == S_LOAD);
  assign ld_en = in_ch.valid && in_ch.ready && (in_ch.col <= in_ch.row);

  always_comb begin
    cmd.i = i;
    cmd.j = j;
    cmd.k = k;
    unique case (state)
      S_PIV:     cmd.op = OP_PIV_RD;
      S_PIV_CHK: cmd.op = OP_PIV_RD;
      S_ROOT:    cmd.op = OP_ROOT;
      S_DIV_RD:  cmd.op = OP_DIV_RD;
      S_DIV:     cmd.op = OP_DIV;
      S_UPD_RD:  cmd.op = OP_UPD_RD;
      S_UPD_MUL: cmd.op = OP_UPD_MUL;
      S_UPD_WR:  cmd.op = OP_UPD_WR;
      S_OUT_RD:  cmd.op = OP_OUT_RD;
      default:   cmd.op = OP_NOP;
    endcase
    if (state == S_ROOT || state == S_DIV_RD || state == S_DIV) begin
      cmd.i = (state == S_ROOT) ? k : i;
      cmd.j = k;
    end
    if (state == S_OUT_RD || state == S_OUT_WAIT) begin
      cmd.k = j;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      out_ch.valid <= 1'b0;
      i <= '0; j <= '0; k <= '0;
      wait1 <= 1'b0;
    end else begin
      wait1 <= 1'b0;
      if (out_ch.valid && out_ch.ready && state != S_OUT_WAIT) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_ch.valid && in_ch.last) begin
            k <= '0;
            state <= S_PIV;
          end
        end
        S_PIV: state <= S_PIV_CHK;
        S_PIV_CHK: begin
          if (sts.piv_bad) begin
            out_ch.valid     <= 1'b1;
            out_ch.out_row   <= k;
            out_ch.out_col   <= k;
            out_ch.out_value <= rd_value;
            out_ch.status    <= 1'b1;
            out_ch.out_last  <= 1'b1;
            state            <= S_ERR;
          end else begin
            wait1 <= 1'b1;
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (!wait1 && !sts.busy) begin
            if (k == nm1) begin
              i <= '0; j <= '0;
              state <= S_OUT_RD;
            end else begin
              i <= k + 3'd1;
              state <= S_DIV_RD;
            end
          end
        end
        S_DIV_RD: begin
          wait1 <= 1'b1;
          state <= S_DIV;
        end
        S_DIV: begin
          if (!wait1 && !sts.busy) begin
            if (i == nm1) begin
              j <= k + 3'd1;
              i <= k + 3'd1;
              state <= S_UPD_RD;
            end else begin
              i <= i + 3'd1;
              state <= S_DIV_RD;
            end
          end
        end
        S_UPD_RD:  state <= S_UPD_MUL;
        S_UPD_MUL: state <= S_UPD_WR;
        S_UPD_WR: begin
          if (i == nm1) begin
            if (j == nm1) begin
              k <= k + 3'd1;
              state <= S_PIV;
            end else begin
              j <= j + 3'd1;
              i <= j + 3'd1;
              state <= S_UPD_RD;
            end
          end else begin
            i <= i + 3'd1;
            state <= S_UPD_RD;
          end
        end
        S_OUT_RD: state <= S_OUT_WAIT;
        S_OUT_WAIT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid     <= 1'b1;
            out_ch.out_row   <= i;
            out_ch.out_col   <= j;
            out_ch.out_value <= rd_value;
            out_ch.status    <= 1'b0;
            out_ch.out_last  <= (i == nm1) && (j == i);
            state            <= S_OUT;
          end
        end
        S_OUT: begin
          if (i == nm1 && j == i) begin
            state <= S_ERR;
          end else begin
            if (j == i) begin
              i <= i + 3'd1;
              j <= '0;
            end else begin
              j <= j + 3'd1;
            end
            state <= S_OUT_RD;
          end
        end
        S_ERR: begin
          if (!out_ch.valid || out_ch.ready) begin
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  `TCF_ASSERT_IMP(a_no_load_busy, clk, rst, state != S_LOAD, !in_ch.ready)
  `TCF_ASSERT_NXT(a_out_hold, clk, rst, out_ch.valid && !out_ch.ready, out_ch.valid)
  `TCF_ASSERT_IMP(a_err_last, clk, rst, out_ch.valid && out_ch.status, out_ch.out_last)
endmodule

// File: rtl/tile_cholesky_factor_unit.sv
// ----------------------------------------------------------------------------
// tile_cholesky_factor_unit
// cholesky factorization of one symmetric q16.16 tile
// ----------------------------------------------------------------------------
// usage: load the lower triangle through in_ch, one element per request, with
// last set on the final element. upper-triangle requests are accepted and
// dropped. after last the unit stops taking loads, factors the tile and sends
// the factor over out_ch in row-major order, out_last on the final element.
// a non-positive pivot gives one request with status 1 and ends the run.
// each pivot is read, checked and rooted in the shared bit-serial root/divide
// unit, which also does each divide; each trailing update is a memory read, a
// multiply and a write. the output register holds while the receiver stalls;
// the sequencer waits. the user must see to it that tile_order is written
// through cfg_we/cfg_data only while the unit is idle, which the unit does not
// enforce. reset (rst, synchronous) returns to loading with tile_order 8; memory
// contents stay undefined until written.
// ----------------------------------------------------------------------------
module tile_cholesky_factor_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data,
  tcf_in_if.sink     in_ch,
  tcf_out_if.source  out_ch
);
  import tcf_pkg::*;

  logic [3:0] tile_order;
  logic       ld_en;
  cmd_t       cmd;
  sts_t       sts;
  val_t       rd_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_order <= ORD_W'(TILE_MAX);
    end else if (cfg_we) begin
      tile_order <= cfg_data;
    end
  end

  tcf_controller u_ctrl (
    .clk, .rst, .tile_order, .in_ch, .out_ch, .ld_en, .cmd, .sts, .rd_value
  );

  tcf_datapath u_dp (
    .clk, .rst, .ld_en, .ld_row(in_ch.row), .ld_col(in_ch.col),
    .ld_value(in_ch.value), .cmd, .sts, .rd_value
  );
endmodule
